[rtl/core/ssl_pkg.sv]
package ssl_pkg;

    // width of a stored segment id magnitude
    localparam int KEY_W = 15;
    // width of the signed segment id on the port
    localparam int ID_W = 16;
    // width of the suppression nesting depth
    localparam int DEPTH_W = 8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

    // default list capacity
    localparam int LIST_SIZE_DEF = 16;

    // command modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_FILTER = 2'd3;

    // decoded command held for the sequencer
    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic             valid;
    } t_cmd;

    // sequencer status back to the top level
    typedef struct packed {
        logic done;
        logic found;
        logic full;
    } t_scan_res;

endpackage

[rtl/core/segment_suppress_list.sv]
// channel   | ports                                  | transfer
// ----------+----------------------------------------+-------------------------------
// command   | start, busy, i_mode, i_seg_id,         | edge with start high, busy low
//           | i_is_mark                              |
// result    | o_strobe, o_in_list, o_draw_enabled,   | edge ending the o_strobe cycle
//           | o_list_full                            |
//
// An unusable id or an empty list skips the search; else the entries are read one a
// cycle through the single read port until a hit or the end of the list, and a
// remove that hits then moves each entry behind the hit down by one place.
// busy is high from the transfer until the strobe cycle.
// Reset is synchronous, active low; it empties the list and clears the depth.
// The result receiver cannot stall: each result is flagged by o_strobe for one cycle only.
module segment_suppress_list
    import ssl_pkg::*;
#(
    parameter int LIST_SIZE = LIST_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic signed [ID_W-1:0] i_seg_id,
    input  logic                   i_is_mark,
    output logic                   o_strobe,
    output logic                   o_in_list,
    output logic                   o_draw_enabled,
    output logic                   o_list_full
);

    logic               accept;
    logic [ID_W-1:0]    mag;
    logic               id_neg;
    t_cmd               cmd;
    t_cmd               r_cmd;
    logic               r_neg;
    logic               r_mark;
    logic               r_busy, n_busy;
    logic               r_go;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_strobe;
    logic               r_in_list;
    logic               r_draw, n_draw;
    logic               r_full;
    t_scan_res          res;

    assign accept = start && !r_busy;

    // magnitude of the id; zero and the most negative value are no key
    assign id_neg    = i_seg_id[ID_W-1];
    assign mag       = id_neg ? (~i_seg_id + 1'b1) : i_seg_id;
    assign cmd.mode  = i_mode;
    assign cmd.key   = mag[KEY_W-1:0];
    assign cmd.valid = (mag != '0) && !mag[ID_W-1];

    ssl_seq #(
        .LIST_SIZE (LIST_SIZE)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_cmd   (r_cmd),
        .o_res   (res)
    );

    // suppression depth and drawing state at the end of the search
    always_comb begin
        n_busy  = r_busy;
        n_depth = r_depth;
        n_draw  = (r_depth == '0);
        if (accept) begin
            n_busy = 1'b1;
        end
        if (res.done) begin
            n_busy = 1'b0;
            if ((r_cmd.mode == MODE_FILTER) && r_mark && res.found) begin
                if (!r_neg) begin
                    n_draw = 1'b0;
                    if (r_depth != DEPTH_MAX) begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (r_depth != '0) begin
                    n_depth = r_depth - 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_go     <= 1'b0;
            r_depth  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_go     <= accept;
            r_depth  <= n_depth;
            r_strobe <= res.done;
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= cmd;
            r_neg  <= id_neg;
            r_mark <= i_is_mark;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_in_list <= res.found;
            r_draw    <= n_draw;
            r_full    <= res.full;
        end
    end

    assign busy           = r_busy;
    assign o_strobe       = r_strobe;
    assign o_in_list      = r_in_list;
    assign o_draw_enabled = r_draw;
    assign o_list_full    = r_full;

    // a result never shows while the block still claims to be busy
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // a command transfer always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // a full list is only reported for an id that was not found
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_list_full) |-> !o_in_list)
        else $error("list full reported for a listed id");

    // one strobe per command: no two strobes back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe repeated");

endmodule

[rtl/core/ssl_mem.sv]
module ssl_mem
    import ssl_pkg::*;
#(
    parameter int LIST_SIZE = LIST_SIZE_DEF,
    parameter int IW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  logic [KEY_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IW-1:0]    i_rd_addr,
    output logic [KEY_W-1:0] o_rd_data
);

    logic [KEY_W-1:0] r_mem [LIST_SIZE];
    logic [KEY_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/ssl_seq.sv]
module ssl_seq
    import ssl_pkg::*;
#(
    parameter int LIST_SIZE = LIST_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_cmd      i_cmd,
    output t_scan_res o_res
);

    localparam int IW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
    localparam int CW = $clog2(LIST_SIZE + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(LIST_SIZE);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_chk, n_chk;
    logic [CW-1:0]    r_chk_idx, n_chk_idx;
    logic             r_found, n_found;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [CW-1:0]    wr_idx;
    logic             issue;
    logic             hit;

    ssl_mem #(
        .LIST_SIZE (LIST_SIZE),
        .IW        (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // sequencer: search one entry a cycle, then compaction or append
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_chk     = 1'b0;
        n_chk_idx = r_addr;
        n_found   = r_found;
        rd_en     = 1'b0;
        rd_addr   = r_addr[IW-1:0];
        wr_en     = 1'b0;
        wr_idx    = r_chk_idx - 1'b1;
        wr_data   = rd_data;
        issue     = 1'b0;
        hit       = 1'b0;
        o_res     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_found = 1'b0;
                    n_addr  = '0;
                    if (i_cmd.valid && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                hit   = r_chk && (rd_data == i_cmd.key);
                issue = (r_addr < r_count) && !hit;
                rd_en = issue;
                n_chk = issue;
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (hit) begin
                    n_found = 1'b1;
                    if (i_cmd.mode == MODE_REMOVE) begin
                        n_addr  = r_chk_idx + 1'b1;
                        n_chk   = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (!issue && !r_chk) begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                // read entry k while entry k-1, read before, is written into entry k-2
                issue = (r_addr < r_count);
                rd_en = issue;
                n_chk = issue;
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                wr_en = r_chk;
                if (!issue && !r_chk) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_res.done  = 1'b1;
                o_res.found = r_found;
                n_state     = S_IDLE;
                if (i_cmd.valid && (i_cmd.mode == MODE_ADD) && !r_found) begin
                    if (r_count < CNT_MAX) begin
                        wr_en   = 1'b1;
                        wr_idx  = r_count;
                        wr_data = i_cmd.key;
                        n_count = r_count + 1'b1;
                    end else begin
                        o_res.full = 1'b1;
                    end
                end
                if ((i_cmd.mode == MODE_REMOVE) && r_found) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        wr_addr = wr_idx[IW-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_chk   <= n_chk;
        end
    end

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_chk_idx <= n_chk_idx;
        r_found   <= n_found;
    end

endmodule
